// ===== rtl/bspl_pkg.sv =====
// Shared types, constants and codes for the partition-tree point locator.
// Used by every module and interface of the block; depends on nothing.
package bspl_pkg;

    localparam int MAX_NODES = 8192;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int STEP_W    = $clog2(MAX_NODES + 1);

    localparam int CNT_W     = 14;
    localparam int IDX_W     = 13;
    localparam int WORD_W    = 32;
    localparam int LINK_W    = 16;
    localparam int LEAF_W    = 15;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 48;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_LOCATE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SIDE,
        ST_MUL_L,
        ST_MUL_R,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] dx;
        logic [WORD_W-1:0] dy;
    } t_line;

    typedef struct packed {
        t_line             line;
        logic [LINK_W-1:0] front_child;
        logic [LINK_W-1:0] back_child;
    } t_node;

    typedef struct packed {
        logic capture;
        logic mul_left;
        logic mul_right;
    } t_side_ctrl;

    typedef struct packed {
        logic quick;
        logic quick_back;
        logic prod_back;
    } t_side_stat;

endpackage

// ===== rtl/bspl_in_if.sv =====
// Input channel of the point locator: node loads and point queries.
// Depends on bspl_pkg for field widths.
interface bspl_in_if;
    import bspl_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [IDX_W-1:0]    node_index;
    logic [WORD_W-1:0]   line_x;
    logic [WORD_W-1:0]   line_y;
    logic [WORD_W-1:0]   line_dx;
    logic [WORD_W-1:0]   line_dy;
    logic [LINK_W-1:0]   front_child;
    logic [LINK_W-1:0]   back_child;
    logic [WORD_W-1:0]   point_x;
    logic [WORD_W-1:0]   point_y;

    modport source (
        output valid, cmd, node_index, line_x, line_y, line_dx, line_dy,
               front_child, back_child, point_x, point_y,
        input  ready
    );

    modport sink (
        input  valid, cmd, node_index, line_x, line_y, line_dx, line_dy,
               front_child, back_child, point_x, point_y,
        output ready
    );

endinterface

// ===== rtl/bspl_out_if.sv =====
// Result channel of the point locator: leaf index and overrun flag.
// Depends on bspl_pkg for field widths.
interface bspl_out_if;
    import bspl_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEAF_W-1:0] leaf_index;
    logic              walk_overrun;

    modport source (
        output valid, leaf_index, walk_overrun,
        input  ready
    );

    modport sink (
        input  valid, leaf_index, walk_overrun,
        output ready
    );

endinterface

// ===== rtl/bspl_node_mem.sv =====
// Node table: one write port for loads, one registered read port for the walk.
// Depends on bspl_pkg for the node entry type and the table depth.
module bspl_node_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [bspl_pkg::NODE_AW-1:0]  i_waddr,
    input  bspl_pkg::t_node               i_wdata,
    input  logic                          i_re,
    input  logic [bspl_pkg::NODE_AW-1:0]  i_raddr,
    output bspl_pkg::t_node               o_rdata
);
    import bspl_pkg::*;

    t_node r_mem [MAX_NODES];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bspl_side_unit.sv =====
// Side test of a point against one partition line, with one shared 16x32 multiplier.
// Depends on bspl_pkg for the line type and the control/status structs.
module bspl_side_unit (
    input  logic                        i_clk,
    input  bspl_pkg::t_line             i_line,
    input  logic [bspl_pkg::WORD_W-1:0] i_px,
    input  logic [bspl_pkg::WORD_W-1:0] i_py,
    input  bspl_pkg::t_side_ctrl        i_ctrl,
    output bspl_pkg::t_side_stat        o_stat
);
    import bspl_pkg::*;

    logic [WORD_W-1:0]        ux;
    logic [WORD_W-1:0]        uy;
    logic [WORD_W-1:0]        r_ux;
    logic [WORD_W-1:0]        r_uy;
    logic [WORD_W-1:0]        r_left;
    logic [WORD_W-1:0]        r_right;
    logic signed [FRAC_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     quick;
    logic                     quick_back;

    assign ux = i_px - i_line.x;
    assign uy = i_py - i_line.y;

    always_comb begin
        quick      = 1'b1;
        quick_back = 1'b0;
        if (i_line.dx == '0) begin
            if ($signed(i_px) <= $signed(i_line.x)) begin
                quick_back = $signed(i_line.dy) > 0;
            end else begin
                quick_back = i_line.dy[WORD_W-1];
            end
        end else if (i_line.dy == '0) begin
            if ($signed(i_py) <= $signed(i_line.y)) begin
                quick_back = i_line.dx[WORD_W-1];
            end else begin
                quick_back = $signed(i_line.dx) > 0;
            end
        end else if (i_line.dy[WORD_W-1] ^ i_line.dx[WORD_W-1]
                     ^ ux[WORD_W-1] ^ uy[WORD_W-1]) begin
            // Operands of opposite sign: the sign bits settle the side alone.
            quick_back = i_line.dy[WORD_W-1] ^ ux[WORD_W-1];
        end else begin
            quick = 1'b0;
        end
    end

    // Integer part of the direction times the offset; the product is then
    // floor-shifted by the fraction width by keeping its upper bits.
    assign mul_a = i_ctrl.mul_left ? i_line.dy[WORD_W-1 -: FRAC_W]
                                   : i_line.dx[WORD_W-1 -: FRAC_W];
    assign mul_b = i_ctrl.mul_left ? r_ux : r_uy;
    assign prod  = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_ux <= ux;
            r_uy <= uy;
        end
        if (i_ctrl.mul_left) begin
            r_left <= prod[PROD_W-1:FRAC_W];
        end
        if (i_ctrl.mul_right) begin
            r_right <= prod[PROD_W-1:FRAC_W];
        end
    end

    assign o_stat.quick      = quick;
    assign o_stat.quick_back = quick_back;
    assign o_stat.prod_back  = !($signed(r_right) < $signed(r_left));

endmodule

// ===== rtl/bsp_point_locate_core.sv =====
// Top level of the partition-tree point locator: walk sequencer and result register.
// Depends on bspl_pkg, bspl_in_if, bspl_out_if, bspl_node_mem and bspl_side_unit.
//
//  channel  | dir | transfer carries
//  ---------+-----+----------------------------------------------------------
//  i_in     | in  | cmd, node_index, line x/y/dx/dy, front/back child, point
//  o_out    | out | leaf_index, walk_overrun (one per locate, none per load)
//  i_cfg_*  | in  | node_count, written on any edge with i_cfg_we high outside reset
//
// A load is taken in the idle state and starts no walk. A locate steps, per visited
// node, through a check, a side test and, when the axis or sign test does not decide,
// the shared multiplier used twice (left, then right) and a compare; it ends with a
// final leaf check and the hand-off to the output register. An empty tree skips the
// leaf check. i_in.ready is low for the whole walk and while a finished result waits
// for the output register.
// Reset is synchronous and clears node_count and all control state; the node
// table is not cleared.
module bsp_point_locate_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bspl_in_if.sink                    i_in,
    bspl_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [bspl_pkg::CNT_W-1:0] i_cfg_data
);
    import bspl_pkg::*;

    t_state              r_state, n_state;
    logic [LINK_W-1:0]   r_cur, n_cur;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [WORD_W-1:0]   r_px, r_py;
    logic [CNT_W-1:0]    r_node_count;
    logic [LEAF_W-1:0]   r_res_leaf, n_res_leaf;
    logic                r_res_ovr, n_res_ovr;
    logic                r_out_valid, n_out_valid;
    logic [LEAF_W-1:0]   r_out_leaf;
    logic                r_out_ovr;

    logic                in_xfer;
    logic                load_we;
    logic                rd_en;
    logic                out_load;
    logic                cur_beyond;
    t_node               node_rd;
    t_node               node_wr;
    t_side_ctrl          side_ctrl;
    t_side_stat          side_stat;

    assign in_xfer = i_in.valid && i_in.ready;
    assign load_we = in_xfer && (t_cmd'(i_in.cmd) == CMD_LOAD)
                     && (32'(i_in.node_index) < 32'(MAX_NODES));

    assign node_wr.line.x      = i_in.line_x;
    assign node_wr.line.y      = i_in.line_y;
    assign node_wr.line.dx     = i_in.line_dx;
    assign node_wr.line.dy     = i_in.line_dy;
    assign node_wr.front_child = i_in.front_child;
    assign node_wr.back_child  = i_in.back_child;

    assign cur_beyond = (32'(r_cur[LEAF_W-1:0]) >= 32'(MAX_NODES));

    bspl_node_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (NODE_AW'(i_in.node_index)),
        .i_wdata (node_wr),
        .i_re    (rd_en),
        .i_raddr (NODE_AW'(r_cur[LEAF_W-1:0])),
        .o_rdata (node_rd)
    );

    bspl_side_unit u_side (
        .i_clk  (i_clk),
        .i_line (node_rd.line),
        .i_px   (r_px),
        .i_py   (r_py),
        .i_ctrl (side_ctrl),
        .o_stat (side_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_res_leaf <= n_res_leaf;
        r_res_ovr  <= n_res_ovr;
        if (in_xfer) begin
            r_px <= i_in.point_x;
            r_py <= i_in.point_y;
        end
        if (out_load) begin
            r_out_leaf <= r_res_leaf;
            r_out_ovr  <= r_res_ovr;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_res_leaf  = r_res_leaf;
        n_res_ovr   = r_res_ovr;
        rd_en       = 1'b0;
        out_load    = 1'b0;
        side_ctrl   = '0;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (t_cmd'(i_in.cmd) == CMD_LOCATE)) begin
                    n_steps = '0;
                    n_cur   = LINK_W'(r_node_count) - LINK_W'(1);
                    if (r_node_count == '0) begin
                        // An empty tree answers leaf 0 without a walk.
                        n_res_leaf = '0;
                        n_res_ovr  = 1'b0;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_cur[LINK_W-1]) begin
                    n_res_leaf = r_cur[LEAF_W-1:0];
                    n_res_ovr  = 1'b0;
                    n_state    = ST_DONE;
                end else if (cur_beyond || (r_steps == STEP_W'(MAX_NODES))) begin
                    n_res_leaf = '0;
                    n_res_ovr  = 1'b1;
                    n_state    = ST_DONE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = ST_SIDE;
                end
            end
            ST_SIDE: begin
                side_ctrl.capture = 1'b1;
                if (side_stat.quick) begin
                    n_cur   = side_stat.quick_back ? node_rd.back_child
                                                   : node_rd.front_child;
                    n_steps = r_steps + STEP_W'(1);
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_MUL_L;
                end
            end
            ST_MUL_L: begin
                side_ctrl.mul_left = 1'b1;
                n_state            = ST_MUL_R;
            end
            ST_MUL_R: begin
                side_ctrl.mul_right = 1'b1;
                n_state             = ST_CMP;
            end
            ST_CMP: begin
                n_cur   = side_stat.prod_back ? node_rd.back_child
                                              : node_rd.front_child;
                n_steps = r_steps + STEP_W'(1);
                n_state = ST_CHECK;
            end
            ST_DONE: begin
                // The result moves to the output register once it is free.
                if (!r_out_valid || o_out.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.leaf_index   = r_out_leaf;
    assign o_out.walk_overrun = r_out_ovr;

endmodule

// ===== rtl/bspl_checker.sv =====
// Port-level checks for the point locator, bound to the top level.
// Depends on bspl_pkg for field widths and command codes.
module bspl_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_in_cmd,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [bspl_pkg::LEAF_W-1:0] i_out_leaf,
    input  logic                        i_out_ovr
);
    import bspl_pkg::*;

    // A pending result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_leaf) && $stable(i_out_ovr))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // The walk owns the block: no transfer is taken right after a locate.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (t_cmd'(i_in_cmd) == CMD_LOCATE) |=> !i_in_ready)
        else $error("input ready during a walk");

    a_ovr_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ovr |-> (i_out_leaf == '0))
        else $error("overrun result with nonzero leaf");

endmodule

bind bsp_point_locate_core bspl_checker u_bspl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_leaf  (o_out.leaf_index),
    .i_out_ovr   (o_out.walk_overrun)
);
